// ----- src/pifp_pkg.sv -----
// Package for the package index field parser: character codes, hash
// constants, result kinds, error codes and the result record type.
// No dependencies.
package pifp_pkg;

  // Bucket count of the key hash and the width of the hash state.
  localparam int HASH_BUCKETS = 256;
  localparam int HASH_W       = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int HASH_SEED    = 5381 % HASH_BUCKETS;

  localparam int MAX_RESULTS = 3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_KEYWORD = 2'd0,
    ERR_NL_IN_KEY   = 2'd1,
    ERR_END_IN_KEY  = 2'd2
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  key_hash;
    logic [15:0] key_length;
    logic [23:0] value_length;
    logic        package_done;
    logic [15:0] package_index;
    logic [23:0] line_number;
    err_t        error_code;
    logic        last;
  } result_t;

  // One djb2 step, h = (h * 33 + c) mod HASH_BUCKETS.
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] c);
    logic [HASH_W+7:0] acc;
    acc = ((HASH_W+8)'(h) << 5) + (HASH_W+8)'(h) + (HASH_W+8)'(c);
    return HASH_W'(acc % HASH_BUCKETS);
  endfunction

  // Reduces the hash state to the eight-bit result field.
  function automatic logic [7:0] hash_field(input logic [HASH_W-1:0] h);
    logic [15:0] wide;
    wide = 16'(h);
    return wide[7:0];
  endfunction

  function automatic result_t mk_result(input kind_t kind, input logic [7:0] data,
                                        input logic [7:0] key_hash,
                                        input logic [15:0] key_length,
                                        input logic [23:0] value_length,
                                        input logic package_done,
                                        input logic [15:0] package_index,
                                        input logic [23:0] line_number,
                                        input err_t error_code);
    result_t r;
    r.kind          = kind;
    r.data          = data;
    r.key_hash      = key_hash;
    r.key_length    = key_length;
    r.value_length  = value_length;
    r.package_done  = package_done;
    r.package_index = package_index;
    r.line_number   = line_number;
    r.error_code    = error_code;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

// ----- src/package_index_field_parser_unit.sv -----
// Top level of the package index field parser: byte-wise record parser and
// three-slot result buffer.
// Depends on pifp_pkg.
//
// The parser takes one byte of a "key: value" package index file per input
// transfer and produces key bytes, value bytes, a field-done record (key hash,
// key and value lengths, package number and whether the package ends) and
// error records. A byte is accepted in every cycle as long as each byte gives
// at most one result and out_ready is high; a byte with more results (at
// most three, for example a continuation newline plus its whitespace, or a
// field end, the next key byte and an end-in-key error at end of input)
// holds the result port until they have left, because the result buffer
// drains one entry per cycle while out_ready is high and takes the next byte
// only once it holds no more than the result leaving in that cycle. Input
// ready therefore depends combinationally on out_ready. After an error the
// parser swallows bytes without results until the byte marked end_of_input,
// and every byte so marked returns the whole parser to its reset state.
module package_index_field_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [7:0]  out_key_hash,
  output logic [15:0] out_key_length,
  output logic [23:0] out_value_length,
  output logic        out_package_done,
  output logic [15:0] out_package_index,
  output logic [23:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_last
);
  import pifp_pkg::*;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_KEY     = 6'b000010,
    PH_VSTART  = 6'b000100,
    PH_VALUE   = 6'b001000,
    PH_NEWLINE = 6'b010000,
    PH_CONT    = 6'b100000
  } phase_t;

  localparam logic [HASH_W-1:0] SEED = HASH_W'(HASH_SEED);

  phase_t            phase_r, phase_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [15:0]       key_cnt_r, key_cnt_nxt;
  logic [23:0]       val_cnt_r, val_cnt_nxt;
  logic [15:0]       pkg_r, pkg_nxt;
  logic [23:0]       line_r, line_nxt;
  logic              halted_r, halted_nxt;

  // Results of the byte on the input, in order, and how many there are.
  result_t           res_nxt [MAX_RESULTS];
  logic [1:0]        new_cnt;

  // Result buffer: slot 0 is what the result port shows.
  result_t           res_r [MAX_RESULTS];
  logic [1:0]        cnt_r, cnt_nxt;

  logic              in_fire, out_fire, blank;

  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && out_ready;
  // A new byte may enter once the buffer is empty or about to be.
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign blank     = (in_data_byte == CH_SPACE) || (in_data_byte == CH_TAB);

  // Parser step. The working values are updated in the same order as the
  // record grammar is walked, so each result picks up the counters as they
  // stand at the moment it is produced.
  always_comb begin
    phase_nxt   = phase_r;
    hash_nxt    = hash_r;
    key_cnt_nxt = key_cnt_r;
    val_cnt_nxt = val_cnt_r;
    pkg_nxt     = pkg_r;
    line_nxt    = line_r;
    halted_nxt  = halted_r;
    new_cnt     = 2'd0;
    res_nxt[0]  = '0;
    res_nxt[1]  = '0;
    res_nxt[2]  = '0;

    if (!halted_r) begin
      unique case (phase_r)
        PH_START: begin
          if (in_data_byte == CH_NL) begin
            if (line_nxt != '1) line_nxt = line_nxt + 24'd1;
          end else if ((in_data_byte == CH_COLON) || blank) begin
            res_nxt[new_cnt] = mk_result(KIND_ERROR, 8'd0, 8'd0, 16'd0, 24'd0, 1'b0,
                                         pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
            new_cnt    = new_cnt + 2'd1;
            halted_nxt = 1'b1;
          end else begin
            hash_nxt    = hash_step(SEED, in_data_byte);
            key_cnt_nxt = 16'd1;
            val_cnt_nxt = 24'd0;
            phase_nxt   = PH_KEY;
            res_nxt[new_cnt] = mk_result(KIND_KEY, in_data_byte, 8'd0, 16'd0, 24'd0,
                                         1'b0, pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
            new_cnt = new_cnt + 2'd1;
          end
        end
        PH_KEY: begin
          if (in_data_byte == CH_COLON) begin
            phase_nxt = PH_VSTART;
          end else if (in_data_byte == CH_NL) begin
            res_nxt[new_cnt] = mk_result(KIND_ERROR, 8'd0, 8'd0, 16'd0, 24'd0, 1'b0,
                                         pkg_nxt, line_nxt, ERR_NL_IN_KEY);
            new_cnt    = new_cnt + 2'd1;
            halted_nxt = 1'b1;
          end else begin
            hash_nxt = hash_step(hash_nxt, in_data_byte);
            if (key_cnt_nxt != '1) key_cnt_nxt = key_cnt_nxt + 16'd1;
            res_nxt[new_cnt] = mk_result(KIND_KEY, in_data_byte, 8'd0, 16'd0, 24'd0,
                                         1'b0, pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
            new_cnt = new_cnt + 2'd1;
          end
        end
        PH_VSTART, PH_VALUE, PH_CONT: begin
          if ((phase_r == PH_VSTART) && (in_data_byte == CH_SPACE)) begin
            // The one space after the colon is dropped.
            phase_nxt = PH_VALUE;
          end else if ((phase_r == PH_CONT) && blank) begin
            if (val_cnt_nxt != '1) val_cnt_nxt = val_cnt_nxt + 24'd1;
            res_nxt[new_cnt] = mk_result(KIND_VALUE, in_data_byte, 8'd0, 16'd0, 24'd0,
                                         1'b0, pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
            new_cnt = new_cnt + 2'd1;
          end else if (in_data_byte == CH_NL) begin
            // The newline is held back until the next byte shows whether
            // the value carries on.
            if (line_nxt != '1) line_nxt = line_nxt + 24'd1;
            phase_nxt = PH_NEWLINE;
          end else begin
            phase_nxt = PH_VALUE;
            if (val_cnt_nxt != '1) val_cnt_nxt = val_cnt_nxt + 24'd1;
            res_nxt[new_cnt] = mk_result(KIND_VALUE, in_data_byte, 8'd0, 16'd0, 24'd0,
                                         1'b0, pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
            new_cnt = new_cnt + 2'd1;
          end
        end
        PH_NEWLINE: begin
          if (blank) begin
            // Continuation line: the held newline and this byte join the value.
            if (val_cnt_nxt != '1) val_cnt_nxt = val_cnt_nxt + 24'd1;
            res_nxt[new_cnt] = mk_result(KIND_VALUE, CH_NL, 8'd0, 16'd0, 24'd0,
                                         1'b0, pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
            new_cnt = new_cnt + 2'd1;
            if (val_cnt_nxt != '1) val_cnt_nxt = val_cnt_nxt + 24'd1;
            res_nxt[new_cnt] = mk_result(KIND_VALUE, in_data_byte, 8'd0, 16'd0, 24'd0,
                                         1'b0, pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
            new_cnt   = new_cnt + 2'd1;
            phase_nxt = PH_CONT;
          end else if (in_data_byte == CH_NL) begin
            // Blank line: the field closes the package.
            res_nxt[new_cnt] = mk_result(KIND_DONE, 8'd0, hash_field(hash_nxt),
                                         key_cnt_nxt, val_cnt_nxt, 1'b1, pkg_nxt,
                                         line_nxt, ERR_BAD_KEYWORD);
            new_cnt = new_cnt + 2'd1;
            if (pkg_nxt != '1) pkg_nxt = pkg_nxt + 16'd1;
            if (line_nxt != '1) line_nxt = line_nxt + 24'd1;
            phase_nxt = PH_START;
          end else begin
            res_nxt[new_cnt] = mk_result(KIND_DONE, 8'd0, hash_field(hash_nxt),
                                         key_cnt_nxt, val_cnt_nxt, 1'b0, pkg_nxt,
                                         line_nxt, ERR_BAD_KEYWORD);
            new_cnt = new_cnt + 2'd1;
            if (in_data_byte == CH_COLON) begin
              res_nxt[new_cnt] = mk_result(KIND_ERROR, 8'd0, 8'd0, 16'd0, 24'd0, 1'b0,
                                           pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
              new_cnt    = new_cnt + 2'd1;
              halted_nxt = 1'b1;
            end else begin
              hash_nxt    = hash_step(SEED, in_data_byte);
              key_cnt_nxt = 16'd1;
              val_cnt_nxt = 24'd0;
              phase_nxt   = PH_KEY;
              res_nxt[new_cnt] = mk_result(KIND_KEY, in_data_byte, 8'd0, 16'd0, 24'd0,
                                           1'b0, pkg_nxt, line_nxt, ERR_BAD_KEYWORD);
              new_cnt = new_cnt + 2'd1;
            end
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end

    if (in_end_of_input) begin
      // Close whatever is still open, then start afresh for the next file.
      if (!halted_nxt) begin
        if (phase_nxt == PH_KEY) begin
          res_nxt[new_cnt] = mk_result(KIND_ERROR, 8'd0, 8'd0, 16'd0, 24'd0, 1'b0,
                                       pkg_nxt, line_nxt, ERR_END_IN_KEY);
          new_cnt = new_cnt + 2'd1;
        end else if (phase_nxt != PH_START) begin
          res_nxt[new_cnt] = mk_result(KIND_DONE, 8'd0, hash_field(hash_nxt),
                                       key_cnt_nxt, val_cnt_nxt, 1'b1, pkg_nxt,
                                       line_nxt, ERR_BAD_KEYWORD);
          new_cnt = new_cnt + 2'd1;
        end
      end
      phase_nxt   = PH_START;
      hash_nxt    = SEED;
      key_cnt_nxt = 16'd0;
      val_cnt_nxt = 24'd0;
      pkg_nxt     = 16'd0;
      line_nxt    = 24'd1;
      halted_nxt  = 1'b0;
    end

    unique case (new_cnt)
      2'd0: ;
      2'd1: res_nxt[0].last = 1'b1;
      2'd2: res_nxt[1].last = 1'b1;
      2'd3: res_nxt[2].last = 1'b1;
    endcase
  end

  // Occupancy of the result buffer. An accepted byte always finds the buffer
  // empty after this cycle's output transfer, so its results simply load.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = new_cnt;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      hash_r    <= SEED;
      key_cnt_r <= 16'd0;
      val_cnt_r <= 24'd0;
      pkg_r     <= 16'd0;
      line_r    <= 24'd1;
      halted_r  <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      if (in_fire) begin
        phase_r   <= phase_nxt;
        hash_r    <= hash_nxt;
        key_cnt_r <= key_cnt_nxt;
        val_cnt_r <= val_cnt_nxt;
        pkg_r     <= pkg_nxt;
        line_r    <= line_nxt;
        halted_r  <= halted_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Buffer payload: loads on an input transfer, shifts down on an output one.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r[0] <= res_nxt[0];
      res_r[1] <= res_nxt[1];
      res_r[2] <= res_nxt[2];
    end else if (out_fire) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  assign out_kind          = res_r[0].kind;
  assign out_out_byte      = res_r[0].data;
  assign out_key_hash      = res_r[0].key_hash;
  assign out_key_length    = res_r[0].key_length;
  assign out_value_length  = res_r[0].value_length;
  assign out_package_done  = res_r[0].package_done;
  assign out_package_index = res_r[0].package_index;
  assign out_line_number   = res_r[0].line_number;
  assign out_error_code    = res_r[0].error_code;
  assign out_last          = res_r[0].last;

  // The final result in the buffer, and only that one, carries last.
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (cnt_r == 2'd1)) |-> res_r[0].last)
    else $error("final buffered result lacks last");

  a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (cnt_r != 2'd1)) |-> !res_r[0].last)
    else $error("last shown before the final result of a byte");

  // While discarding after an error, accepted bytes give no results.
  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && halted_r) |=> (cnt_r == 2'd0))
    else $error("result produced while halted");

  // The end of input returns the parser to its reset state.
  a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_input) |=>
      ((phase_r == PH_START) && (line_r == 24'd1) && !halted_r && (pkg_r == 16'd0)))
    else $error("state not reset after end of input");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for package_index_field_parser_unit: byte stimulus,
// an in-bench model of the record parser and a field-by-field result check.
// Depends on pifp_pkg and the parser top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pifp_pkg::*;

  // Watchdog limit in cycles without any transfer on either channel. The
  // long receiver hold-off below is well inside it.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_BYTES  = 280;
  localparam int unsigned DRAIN_CYCLES  = 16;

  // States of the in-bench parser model.
  typedef enum logic [2:0] {
    ST_RECORD,
    ST_KEY,
    ST_VAL_START,
    ST_VALUE,
    ST_NEWLINE,
    ST_CONT
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [7:0]  out_key_hash;
  logic [15:0] out_key_length;
  logic [23:0] out_value_length;
  logic        out_package_done;
  logic [15:0] out_package_index;
  logic [23:0] out_line_number;
  logic [1:0]  out_error_code;
  logic        out_last;

  package_index_field_parser_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_out_byte      (out_out_byte),
    .out_key_hash      (out_key_hash),
    .out_key_length    (out_key_length),
    .out_value_length  (out_value_length),
    .out_package_done  (out_package_done),
    .out_package_index (out_package_index),
    .out_line_number   (out_line_number),
    .out_error_code    (out_error_code),
    .out_last          (out_last)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes still to be offered, and the parser output that accepted bytes
  // are known to owe, oldest first.
  file_byte_t  file_bytes[$];
  result_t     tokens_due[$];
  result_t     byte_tokens[$];
  file_byte_t  next_byte;

  int unsigned total_bytes = 0;
  int unsigned bytes_accepted = 0;
  int unsigned fail_cnt = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};
  int unsigned stall_cnt = 0;
  int unsigned hold_left = 0;
  bit          pressure_done = 1'b0;

  // Model state: it mirrors what the parser must hold between bytes.
  parse_state_t pstate;
  int unsigned  hash_acc;
  int unsigned  key_cnt;
  int unsigned  val_cnt;
  int unsigned  pkg_cnt;
  int unsigned  line_cnt;
  bit           halted;

  // ------------------------------------------------------------------
  // Parser model
  // ------------------------------------------------------------------

  // Returns every counter to its power-on value. The parser does the same
  // after each byte marked as the end of the file.
  function automatic void clear_parser();
    pstate   = ST_RECORD;
    hash_acc = 5381 % HASH_BUCKETS;
    key_cnt  = 0;
    val_cnt  = 0;
    pkg_cnt  = 0;
    line_cnt = 1;
    halted   = 1'b0;
  endfunction

  // Every token carries the current package and line numbers, whatever its
  // kind; the other fields are zero unless the kind uses them.
  function automatic void add_token(kind_t k, logic [7:0] b, int unsigned h,
                                    int unsigned kl, int unsigned vl,
                                    bit pd, err_t e);
    result_t r;
    r.kind          = k;
    r.data          = b;
    r.key_hash      = 8'(h);
    r.key_length    = 16'(kl);
    r.value_length  = 24'(vl);
    r.package_done  = pd;
    r.package_index = 16'(pkg_cnt);
    r.line_number   = 24'(line_cnt);
    r.error_code    = e;
    r.last          = 1'b0;
    byte_tokens.push_back(r);
  endfunction

  function automatic void next_line();
    if (line_cnt < 24'hFF_FFFF) line_cnt++;
  endfunction

  // An error silences the parser until the end of the file.
  function automatic void flag_error(err_t e);
    add_token(KIND_ERROR, 8'd0, 0, 0, 0, 1'b0, e);
    halted = 1'b1;
  endfunction

  function automatic void key_char(logic [7:0] c);
    hash_acc = (hash_acc * 33 + c) % HASH_BUCKETS;
    if (key_cnt < 16'hFFFF) key_cnt++;
    add_token(KIND_KEY, c, 0, 0, 0, 1'b0, ERR_BAD_KEYWORD);
  endfunction

  function automatic void open_key(logic [7:0] c);
    hash_acc = 5381 % HASH_BUCKETS;
    key_cnt  = 0;
    val_cnt  = 0;
    pstate   = ST_KEY;
    key_char(c);
  endfunction

  function automatic void value_char(logic [7:0] c);
    if (val_cnt < 24'hFF_FFFF) val_cnt++;
    add_token(KIND_VALUE, c, 0, 0, 0, 1'b0, ERR_BAD_KEYWORD);
  endfunction

  // A newline inside a value is held back: only the next byte shows whether
  // it continues the value or ends the field.
  function automatic void value_input(logic [7:0] c);
    if (c == CH_NL) begin
      next_line();
      pstate = ST_NEWLINE;
    end else begin
      pstate = ST_VALUE;
      value_char(c);
    end
  endfunction

  function automatic void close_field(bit pd);
    add_token(KIND_DONE, 8'd0, hash_acc, key_cnt, val_cnt, pd, ERR_BAD_KEYWORD);
  endfunction

  // Works out the tokens that one accepted byte owes and queues them.
  function automatic void parse_byte(logic [7:0] c, logic eoi);
    bit blank;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    byte_tokens.delete();
    if (halted) begin
      if (eoi) clear_parser();
      return;
    end
    case (pstate)
      ST_RECORD: begin
        if (c == CH_NL) next_line();
        else if (c == CH_COLON || blank) flag_error(ERR_BAD_KEYWORD);
        else open_key(c);
      end
      ST_KEY: begin
        if (c == CH_COLON) pstate = ST_VAL_START;
        else if (c == CH_NL) flag_error(ERR_NL_IN_KEY);
        else key_char(c);
      end
      ST_VAL_START: begin
        // Only the first space after the colon is dropped.
        if (c == CH_SPACE) pstate = ST_VALUE;
        else value_input(c);
      end
      ST_VALUE: begin
        value_input(c);
      end
      ST_NEWLINE: begin
        if (blank) begin
          // Continuation line: the held newline now belongs to the value.
          value_char(CH_NL);
          value_char(c);
          pstate = ST_CONT;
        end else if (c == CH_NL) begin
          // Blank line: the field closes the package.
          close_field(1'b1);
          if (pkg_cnt < 16'hFFFF) pkg_cnt++;
          next_line();
          pstate = ST_RECORD;
        end else begin
          close_field(1'b0);
          if (c == CH_COLON) flag_error(ERR_BAD_KEYWORD);
          else open_key(c);
        end
      end
      ST_CONT: begin
        if (blank) value_char(c);
        else value_input(c);
      end
      default: begin
        pstate = ST_RECORD;
      end
    endcase
    if (eoi) begin
      if (!halted) begin
        if (pstate == ST_KEY) flag_error(ERR_END_IN_KEY);
        else if (pstate != ST_RECORD) close_field(1'b1);
      end
      clear_parser();
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
  endfunction

  // ------------------------------------------------------------------
  // Stimulus generation
  // ------------------------------------------------------------------

  function automatic void push_item(logic [7:0] b, bit eoi);
    file_byte_t f;
    f.data = b;
    f.eoi  = eoi;
    file_bytes.push_back(f);
  endfunction

  // Queues a short text; the end-of-file mark goes on its final byte.
  function automatic void add_text(string s, bit eoi_last);
    for (int i = 0; i < s.len(); i++) push_item(s[i], eoi_last && (i == s.len() - 1));
  endfunction

  // Bytes biased towards the characters that steer the parser.
  function automatic logic [7:0] steering_char();
    case ($urandom_range(0, 5))
      0: return CH_COLON;
      1: return CH_NL;
      2: return CH_SPACE;
      3: return CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Any byte but a newline, as found inside a value.
  function automatic logic [7:0] value_char_rand();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_NL) b = 8'h0B;
    return b;
  endfunction

  function automatic logic [7:0] key_char_rand(bit first);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_COLON || b == CH_NL ||
               (first && (b == CH_SPACE || b == CH_TAB)));
    return b;
  endfunction

  // Builds one file. Most are well-formed packages with random keys and
  // values; the rest are either pure noise or well-formed files with one
  // byte broken, so that every error path is reached from deep states too.
  function automatic void add_random_file();
    logic [7:0] f[$];
    int         npkg;
    int         nfld;
    int         len;
    int         pos;
    int         style;
    style = int'($urandom_range(0, 9));
    if (style == 0) begin
      len = int'($urandom_range(1, 12));
      for (int i = 0; i < len; i++) f.push_back(steering_char());
    end else begin
      if ($urandom_range(0, 3) == 0) f.push_back(CH_NL);
      npkg = int'($urandom_range(1, 2));
      for (int p = 0; p < npkg; p++) begin
        nfld = int'($urandom_range(1, 3));
        for (int k = 0; k < nfld; k++) begin
          len = int'($urandom_range(1, 4));
          for (int i = 0; i < len; i++) f.push_back(key_char_rand(i == 0));
          f.push_back(CH_COLON);
          if ($urandom_range(0, 3) != 0) f.push_back(CH_SPACE);
          len = int'($urandom_range(0, 5));
          for (int i = 0; i < len; i++) f.push_back(value_char_rand());
          if ($urandom_range(0, 3) == 0) begin
            // A continuation line, opened by a space or a tab.
            f.push_back(CH_NL);
            f.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
            len = int'($urandom_range(0, 3));
            for (int i = 0; i < len; i++) f.push_back(value_char_rand());
          end
          if (k + 1 < nfld) f.push_back(CH_NL);
        end
        if (p + 1 < npkg) begin
          f.push_back(CH_NL);
          f.push_back(CH_NL);
        end else if ($urandom_range(0, 1) == 0) begin
          f.push_back(CH_NL);
        end
      end
      if (style == 1) begin
        pos = int'($urandom_range(0, f.size() - 1));
        f[pos] = steering_char();
      end
    end
    foreach (f[i]) push_item(f[i], i == f.size() - 1);
  endfunction

  // ------------------------------------------------------------------
  // Driver: offers queued bytes and feeds accepted ones to the model.
  // ------------------------------------------------------------------

  // Idle percentages per run phase: sender 37 and receiver 79 first, then
  // the other way round, then no idling at all.
  function automatic int unsigned idle_pct(bit receiver);
    int unsigned phase;
    phase = (bytes_accepted * 3) / total_bytes;
    if (phase == 0) return receiver ? 79 : 37;
    if (phase == 1) return receiver ? 37 : 79;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_data_byte    <= 8'd0;
      in_end_of_input <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_data_byte, in_end_of_input);
        bytes_accepted <= bytes_accepted + 1;
      end
      // A new byte may be offered only once the current one has transferred.
      // During the receiver hold-off the sender never idles, so the parser
      // fills up and has to stall its input.
      if (!in_valid || in_ready) begin
        if (file_bytes.size() > 0 &&
            (hold_left > 0 || $urandom_range(0, 99) >= idle_pct(1'b0))) begin
          next_byte       = file_bytes.pop_front();
          in_valid        <= 1'b1;
          in_data_byte    <= next_byte.data;
          in_end_of_input <= next_byte.eoi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off half way.
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!pressure_done && bytes_accepted >= total_bytes / 2) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // ------------------------------------------------------------------
  // Monitor: compares each result transfer with the oldest expectation.
  // ------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_tok;
    if (rst_n && out_valid && out_ready) begin
      kind_seen[out_kind]++;
      if (tokens_due.size() == 0) begin
        $error("unexpected result transfer: kind %0d, byte 0x%0h", out_kind, out_out_byte);
        fail_cnt++;
      end else begin
        exp_tok = tokens_due.pop_front();
        check_field("out_kind", exp_tok.kind, out_kind);
        check_field("out_out_byte", exp_tok.data, out_out_byte);
        check_field("out_key_hash", exp_tok.key_hash, out_key_hash);
        check_field("out_key_length", exp_tok.key_length, out_key_length);
        check_field("out_value_length", exp_tok.value_length, out_value_length);
        check_field("out_package_done", exp_tok.package_done, out_package_done);
        check_field("out_package_index", exp_tok.package_index, out_package_index);
        check_field("out_line_number", exp_tok.line_number, out_line_number);
        check_field("out_error_code", exp_tok.error_code, out_error_code);
        check_field("out_last", exp_tok.last, out_last);
      end
    end
  end

  // Watchdog: a run that stops moving ends here.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, tokens_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------

  initial begin
    int unsigned directed_cnt;
    clear_parser();

    // Directed part. The first file has a leading blank line, a dropped
    // space after the colon, continuation lines opened by a space and by a
    // tab, a whitespace-only continuation line, a field with no space after
    // its colon, a blank line between packages, and ends inside a key.
    add_text("\nA: x\n y\n\t\nB:z\n\nC", 1'b1);
    // A tab, a colon and a space at the start of a record; the byte after
    // the space is swallowed up to the end mark.
    add_text("\t", 1'b1);
    add_text(":", 1'b1);
    add_text(" q", 1'b1);
    // A newline inside a key.
    add_text("K\n:", 1'b1);
    // A colon at the start of the line after a field: field done, then error.
    add_text("a:b\n:", 1'b1);
    // Zero byte as a key, top byte as a value, closed by the end of input.
    push_item(8'h00, 1'b0);
    push_item(CH_COLON, 1'b0);
    push_item(8'hFF, 1'b1);
    directed_cnt = file_bytes.size();

    while (file_bytes.size() < directed_cnt + RANDOM_BYTES) add_random_file();
    total_bytes = file_bytes.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted != total_bytes || tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d bytes (%0d directed); results seen: %0d key, %0d value,",
             total_bytes, directed_cnt, kind_seen[KIND_KEY], kind_seen[KIND_VALUE]);
    $display("%0d field-done and %0d error, with one long receiver hold-off.",
             kind_seen[KIND_DONE], kind_seen[KIND_ERROR]);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
